@@ rtl/barycentric_coordinates_3d_macros.svh @@
// Assertion macros for the barycentric weight block.
`ifndef BARYCENTRIC_COORDINATES_3D_MACROS_SVH
`define BARYCENTRIC_COORDINATES_3D_MACROS_SVH
`ifndef ASSERT_OFF
`define BC3_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("bc3 check failed");
`define BC3_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("bc3 check failed");
`else
`define BC3_ASSERT(lbl, clk, rst, prop)
`define BC3_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

@@ rtl/bc3_pkg.sv @@
`default_nettype none
package bc3_pkg;
  localparam int COORD_BITS     = 24;
  localparam int WFRAC_DEFAULT  = 24;
  // difference width and wrapped cross-term width
  localparam int DW = COORD_BITS + 1;
  localparam int NW = (2 * DW + 1 > 64) ? 64 : 2 * DW + 1;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic signed [COORD_BITS-1:0] corner_a_x;
    logic signed [COORD_BITS-1:0] corner_a_y;
    logic signed [COORD_BITS-1:0] corner_a_z;
    logic signed [COORD_BITS-1:0] corner_b_x;
    logic signed [COORD_BITS-1:0] corner_b_y;
    logic signed [COORD_BITS-1:0] corner_b_z;
    logic signed [COORD_BITS-1:0] corner_c_x;
    logic signed [COORD_BITS-1:0] corner_c_y;
    logic signed [COORD_BITS-1:0] corner_c_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] weight_a;
    logic signed [31:0] weight_b;
    logic signed [31:0] weight_c;
    logic               ok;
  } out_word_t;

  // numerators, denominator and threshold verdict between front and back
  typedef struct packed {
    logic signed [NW-1:0] nb;
    logic signed [NW-1:0] nc;
    logic signed [NW-1:0] den;
    logic                 ok;
  } mid_word_t;

  function automatic logic [NW-1:0] mag_nw(input logic signed [NW-1:0] v);
    return v[NW-1] ? (~v + NW'(1)) : v;
  endfunction
endpackage
`default_nettype wire

@@ rtl/barycentric_coordinates_3d.sv @@
// Barycentric weights of a point against a 3D triangle, signed Q12.12 in,
// signed Q8.24 out (fraction set by WEIGHT_FRAC_BITS), saturated. One word
// in and one word out per clock sustained while neither side stalls; words
// pass through the front, the two-word hand-off queue and the back, where
// two dividers of 32 quotient-bit stages set the depth. The triangle is
// flagged degenerate (ok low, weights zero) when the largest normal
// component magnitude, in raw Q24.24 units, is at or below min_normal.
// min_normal resets to zero and should only be written while idle.
`default_nettype none
`include "barycentric_coordinates_3d_macros.svh"
module barycentric_coordinates_3d import bc3_pkg::*; #(
  parameter int WEIGHT_FRAC_BITS = WFRAC_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  in_word_t    item,
  input  logic        push,
  output logic        full,
  output out_word_t   result,
  output logic        empty,
  input  logic        pop,
  input  logic        min_normal_we,
  input  logic [31:0] min_normal_wdata
);
  logic [31:0] min_normal;
  mid_word_t   mid_in, mid_out;
  logic        mid_push, mid_full, mid_pop, mid_empty;
  logic        weights_zero;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_normal <= '0;
    end else if (min_normal_we) begin
      min_normal <= min_normal_wdata;
    end
  end

  // front: edge vectors, normal, axis pick, projected cross terms
  bc3_front u_front (
    .clk(clk), .rst(rst), .item(item), .push(push), .full(full),
    .min_normal(min_normal), .mid(mid_in), .mid_push(mid_push), .mid_full(mid_full)
  );

  // short queue so front and back stall apart
  bc3_fifo2 u_queue (
    .clk(clk), .rst(rst), .wdata(mid_in), .wr(mid_push), .full(mid_full),
    .rdata(mid_out), .rd(mid_pop), .empty(mid_empty)
  );

  // back: divides, saturation, weight_a, output register
  bc3_back #(.WFRAC(WEIGHT_FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .mid(mid_out), .mid_empty(mid_empty), .mid_pop(mid_pop),
    .result(result), .empty(empty), .pop(pop)
  );

  assign weights_zero = result.weight_a == 0 && result.weight_b == 0 &&
                        result.weight_c == 0;

  `BC3_ASSERT(a_no_queue_overrun, clk, rst, mid_push |-> !mid_full)
  `BC3_ASSERT(a_degen_zero, clk, rst, (!empty && !result.ok) |-> weights_zero)
  `BC3_ASSERT(a_ready_after_reset, clk, rst, $past(rst) |-> !full)
endmodule
`default_nettype wire

@@ rtl/bc3_front.sv @@
`default_nettype none
module bc3_front import bc3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  in_word_t    item,
  input  logic        push,
  output logic        full,
  input  logic [31:0] min_normal,
  output mid_word_t   mid,
  output logic        mid_push,
  input  logic        mid_full
);
  logic       en;
  logic [4:0] v;
  logic signed [DW-1:0] pk [3];
  logic signed [DW-1:0] ak [3];
  logic signed [DW-1:0] bk [3];
  logic signed [DW-1:0] ck [3];
  logic signed [DW-1:0] u1 [3];
  logic signed [DW-1:0] w1 [3];
  logic signed [DW-1:0] p1 [3];
  logic signed [DW-1:0] u2 [3];
  logic signed [DW-1:0] w2 [3];
  logic signed [DW-1:0] p2 [3];
  logic signed [DW-1:0] u3 [3];
  logic signed [DW-1:0] w3 [3];
  logic signed [DW-1:0] p3 [3];
  logic signed [NW-1:0] n2 [3];
  logic [NW-1:0]        am [3];
  logic [1:0]           axis_next;
  logic [1:0]           axis3;
  logic signed [NW-1:0] den3;
  logic [NW-1:0]        dm3;
  logic signed [NW-1:0] pr4 [4];
  logic signed [NW-1:0] den4;
  logic                 ok4;
  logic signed [DW-1:0] ui, uj, wi, wj, pi, pj;

  function automatic logic signed [NW-1:0] mulw(input logic signed [DW-1:0] a,
                                                input logic signed [DW-1:0] b);
    logic signed [2*DW-1:0] pr;
    pr = a * b;
    return NW'(pr);
  endfunction

  assign en       = !v[4] || !mid_full;
  assign full     = !en;
  assign mid_push = v[4] && !mid_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[3:0], push};
    end
  end

  always_comb begin
    pk[0] = DW'(item.point_x);    pk[1] = DW'(item.point_y);    pk[2] = DW'(item.point_z);
    ak[0] = DW'(item.corner_a_x); ak[1] = DW'(item.corner_a_y); ak[2] = DW'(item.corner_a_z);
    bk[0] = DW'(item.corner_b_x); bk[1] = DW'(item.corner_b_y); bk[2] = DW'(item.corner_b_z);
    ck[0] = DW'(item.corner_c_x); ck[1] = DW'(item.corner_c_y); ck[2] = DW'(item.corner_c_z);
  end

  // dominant axis; ties go to the later axis
  always_comb begin
    for (int k = 0; k < 3; k++) am[k] = mag_nw(n2[k]);
    if (am[0] > am[1]) axis_next = (am[0] > am[2]) ? AXIS_X : AXIS_Z;
    else               axis_next = (am[1] > am[2]) ? AXIS_Y : AXIS_Z;
  end

  // projection plane axes i, j
  always_comb begin
    case (axis3)
      AXIS_X: begin
        ui = u3[1]; uj = u3[2]; wi = w3[1]; wj = w3[2]; pi = p3[1]; pj = p3[2];
      end
      AXIS_Y: begin
        ui = u3[2]; uj = u3[0]; wi = w3[2]; wj = w3[0]; pi = p3[2]; pj = p3[0];
      end
      default: begin
        ui = u3[0]; uj = u3[1]; wi = w3[0]; wj = w3[1]; pi = p3[0]; pj = p3[1];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p1[k] <= pk[k] - ak[k];
        u1[k] <= bk[k] - ak[k];
        w1[k] <= ck[k] - ak[k];
      end
      u2 <= u1; w2 <= w1; p2 <= p1;
      n2[0] <= mulw(u1[1], w1[2]) - mulw(u1[2], w1[1]);
      n2[1] <= mulw(u1[2], w1[0]) - mulw(u1[0], w1[2]);
      n2[2] <= mulw(u1[0], w1[1]) - mulw(u1[1], w1[0]);
      u3 <= u2; w3 <= w2; p3 <= p2;
      axis3 <= axis_next;
      case (axis_next)
        AXIS_X:  begin den3 <= n2[0]; dm3 <= am[0]; end
        AXIS_Y:  begin den3 <= n2[1]; dm3 <= am[1]; end
        default: begin den3 <= n2[2]; dm3 <= am[2]; end
      endcase
      pr4[0] <= mulw(pi, wj);
      pr4[1] <= mulw(pj, wi);
      pr4[2] <= mulw(ui, pj);
      pr4[3] <= mulw(uj, pi);
      den4   <= den3;
      ok4    <= 64'(dm3) > 64'(min_normal);
      mid.nb  <= pr4[0] - pr4[1];
      mid.nc  <= pr4[2] - pr4[3];
      mid.den <= den4;
      mid.ok  <= ok4;
    end
  end
endmodule
`default_nettype wire

@@ rtl/bc3_fifo2.sv @@
`default_nettype none
module bc3_fifo2 import bc3_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  mid_word_t wdata,
  input  logic      wr,
  output logic      full,
  output mid_word_t rdata,
  input  logic      rd,
  output logic      empty
);
  mid_word_t  mem [2];
  logic       wp, rp;
  logic [1:0] count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; count <= '0;
    end else begin
      if (wr && !full) wp <= ~wp;
      if (rd && !empty) rp <= ~rp;
      count <= count + 2'((wr && !full) ? 1 : 0) - 2'((rd && !empty) ? 1 : 0);
    end
  end

  always_ff @(posedge clk) begin
    if (wr && !full) mem[wp] <= wdata;
  end
endmodule
`default_nettype wire

@@ rtl/bc3_div.sv @@
`default_nettype none
module bc3_div import bc3_pkg::*; #(
  parameter int WFRAC = WFRAC_DEFAULT
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic signed [NW-1:0] den,
  output logic [31:0]          q,
  output logic                 neg
);
  localparam int W = NW + 33;
  logic [W-1:0]  r  [0:32];
  logic [NW-1:0] dd [0:32];
  logic [31:0]   qq [0:32];
  logic          ng [0:32];
  logic          ov [0:32];
  logic [NW-1:0] a, d;

  assign a = mag_nw(num);
  assign d = mag_nw(den);

  always_ff @(posedge clk) begin
    if (en) begin
      r[0]  <= W'(a) << WFRAC;
      dd[0] <= d;
      qq[0] <= '0;
      ng[0] <= num[NW-1] ^ den[NW-1];
      ov[0] <= (W'(a) << WFRAC) >= (W'(d) << 32);
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar i = 1; i <= 32; i++) begin : g_bit
    logic [W-1:0] ds;
    logic         ge;
    assign ds = W'(dd[i-1]) << (32 - i);
    assign ge = r[i-1] >= ds;
    always_ff @(posedge clk) begin
      if (en) begin
        r[i]  <= ge ? r[i-1] - ds : r[i-1];
        dd[i] <= dd[i-1];
        qq[i] <= qq[i-1] | (32'(ge) << (32 - i));
        ng[i] <= ng[i-1];
        ov[i] <= ov[i-1];
      end
    end
  end

  assign q   = ov[32] ? '1 : qq[32];
  assign neg = ng[32];
endmodule
`default_nettype wire

@@ rtl/bc3_back.sv @@
`default_nettype none
module bc3_back import bc3_pkg::*; #(
  parameter int WFRAC = WFRAC_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  mid_word_t mid,
  input  logic      mid_empty,
  output logic      mid_pop,
  output out_word_t result,
  output logic      empty,
  input  logic      pop
);
  localparam logic signed [33:0] SMAX = 34'sh07FFFFFFF;
  localparam logic signed [33:0] SMIN = -34'sh080000000;

  logic          en;
  logic [33:0]   v;
  logic [32:0]   okd;
  logic [31:0]   qb, qc;
  logic          nb_neg, nc_neg;
  logic signed [31:0] wb, wc;
  logic signed [33:0] sa;
  logic signed [31:0] wa;

  function automatic logic signed [31:0] satw(input logic [31:0] q, input logic ng);
    if (ng) return (q > 32'h80000000) ? 32'sh80000000 : -q;
    return (q > 32'h7FFFFFFF) ? 32'sh7FFFFFFF : q;
  endfunction

  assign en      = !v[33] || pop;
  assign mid_pop = !mid_empty && en;
  assign empty   = !v[33];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[32:0], !mid_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (en) okd <= {okd[31:0], mid.ok};
  end

  bc3_div #(.WFRAC(WFRAC)) u_div_b (
    .clk(clk), .en(en), .num(mid.nb), .den(mid.den), .q(qb), .neg(nb_neg)
  );
  bc3_div #(.WFRAC(WFRAC)) u_div_c (
    .clk(clk), .en(en), .num(mid.nc), .den(mid.den), .q(qc), .neg(nc_neg)
  );

  always_comb begin
    wb = satw(qb, nb_neg);
    wc = satw(qc, nc_neg);
    sa = (34'sd1 <<< WFRAC) - 34'(wb) - 34'(wc);
    if (sa > SMAX)      wa = 32'sh7FFFFFFF;
    else if (sa < SMIN) wa = 32'sh80000000;
    else                wa = 32'(sa);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.ok       <= okd[32];
      result.weight_a <= okd[32] ? wa : '0;
      result.weight_b <= okd[32] ? wb : '0;
      result.weight_c <= okd[32] ? wc : '0;
    end
  end
endmodule
`default_nettype wire

@@ bench/barycentric_coordinates_3d_test.sv @@
`default_nettype none
module barycentric_coordinates_3d_test;
  import bc3_pkg::*;

  // Drain wait that covers the result path through front, queue and dividers.
  localparam int LATENCY     = 40;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  in_word_t    item = '0;
  logic        push = 1'b0;
  logic        full;
  out_word_t   result;
  logic        empty;
  logic        pop = 1'b0;
  logic        min_normal_we = 1'b0;
  logic [31:0] min_normal_wdata = '0;

  barycentric_coordinates_3d uut (
    .clk              (clk),
    .rst              (rst),
    .item             (item),
    .push             (push),
    .full             (full),
    .result           (result),
    .empty            (empty),
    .pop              (pop),
    .min_normal_we    (min_normal_we),
    .min_normal_wdata (min_normal_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predictor's own copy of the threshold register.
  logic [31:0] threshold;
  out_word_t   weights_due[$];
  int          errors;
  int          words_sent;
  int          words_checked;
  int          degenerate_seen;
  int          cycles;
  int          stall_mode;  // 0 never stall, 1 light, 2 heavy

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    if (errors <= 30)
      $display("mismatch word %0d %s: got %h want %h", words_checked, what, got, want);
  endtask

  // Signed 64-bit helpers; products fit since coordinates are 24 bits.
  function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  // Quotient in Q8.24, truncated toward zero, saturated.
  function automatic logic signed [63:0] weight_div(input logic signed [63:0] num,
                                                    input logic signed [63:0] den);
    logic neg;
    logic [63:0] a, d, q, r;
    neg = num[63] ^ den[63];
    a = num[63] ? -num : num;
    d = den[63] ? -den : den;
    q = a / d;
    r = a % d;
    if (q >= 64'd256) begin
      q = 64'hFFFF_FFFF;
    end else begin
      for (int i = 0; i < 24; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= d) begin
          r = r - d;
          q[0] = 1'b1;
        end
      end
    end
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return -$signed(q);
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return $signed(q);
  endfunction

  function automatic out_word_t barycentric_weights(input in_word_t w);
    logic signed [63:0] p[3], u[3], v[3], n[3], nb, nc, den, wb, wc, wa;
    logic [63:0] m[3], dm;
    logic [1:0] axis;
    out_word_t o;
    p[0] = w.point_x - w.corner_a_x;
    p[1] = w.point_y - w.corner_a_y;
    p[2] = w.point_z - w.corner_a_z;
    u[0] = w.corner_b_x - w.corner_a_x;
    u[1] = w.corner_b_y - w.corner_a_y;
    u[2] = w.corner_b_z - w.corner_a_z;
    v[0] = w.corner_c_x - w.corner_a_x;
    v[1] = w.corner_c_y - w.corner_a_y;
    v[2] = w.corner_c_z - w.corner_a_z;
    n[0] = u[1] * v[2] - u[2] * v[1];
    n[1] = u[2] * v[0] - u[0] * v[2];
    n[2] = u[0] * v[1] - u[1] * v[0];
    for (int k = 0; k < 3; k++) m[k] = n[k][63] ? -n[k] : n[k];
    // ties go to the later axis
    if (m[0] > m[1]) axis = (m[0] > m[2]) ? AXIS_X : AXIS_Z;
    else             axis = (m[1] > m[2]) ? AXIS_Y : AXIS_Z;
    case (axis)
      AXIS_X: begin
        nb = p[1] * v[2] - p[2] * v[1];
        nc = u[1] * p[2] - u[2] * p[1];
      end
      AXIS_Y: begin
        nb = p[2] * v[0] - p[0] * v[2];
        nc = u[2] * p[0] - u[0] * p[2];
      end
      default: begin
        nb = p[0] * v[1] - p[1] * v[0];
        nc = u[0] * p[1] - u[1] * p[0];
      end
    endcase
    den = n[axis];
    dm = m[axis];
    o = '0;
    if (dm <= {32'd0, threshold}) return o;
    wb = weight_div(nb, den);
    wc = weight_div(nc, den);
    wa = sat32(64'sd16777216 - wb - wc);
    o.weight_b = wb[31:0];
    o.weight_c = wc[31:0];
    o.weight_a = wa[31:0];
    o.ok = 1'b1;
    return o;
  endfunction

  // Receiver: pop on its own stall pattern, check each word on acceptance.
  always @(posedge clk) begin
    out_word_t want;
    if (!rst && pop && !empty) begin
      words_checked++;
      if (weights_due.size() == 0) begin
        errors++;
        $display("unexpected result word %0d", words_checked);
      end else begin
        want = weights_due.pop_front();
        if (result.weight_a !== want.weight_a)
          report("weight_a", result.weight_a, want.weight_a);
        if (result.weight_b !== want.weight_b)
          report("weight_b", result.weight_b, want.weight_b);
        if (result.weight_c !== want.weight_c)
          report("weight_c", result.weight_c, want.weight_c);
        if (result.ok !== want.ok) report("ok", 32'(result.ok), 32'(want.ok));
        if (!want.ok) degenerate_seen++;
      end
    end
    case (stall_mode)
      0: pop <= 1'b1;
      1: pop <= ($urandom_range(0, 3) != 0);
      default: pop <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // Sender side: burst/gap state shared by every test task.
  int burst_left;

  task automatic send_word(input in_word_t w);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      // gap between bursts; often none
      if ($urandom_range(0, 2) == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    item <= w;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    weights_due.push_back(barycentric_weights(w));
    words_sent++;
  endtask

  task automatic drain;
    push <= 1'b0;
    while (weights_due.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [31:0] value);
    min_normal_we <= 1'b1;
    min_normal_wdata <= value;
    @(posedge clk);
    min_normal_we <= 1'b0;
    threshold = value;
  endtask

  function automatic logic signed [23:0] any_coord();
    case ($urandom_range(0, 5))
      0: return 24'sh7FFFFF;
      1: return -24'sh800000;
      2: return 24'($urandom_range(0, 8191) - 4096);
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    w = '0;
    w.point_x = any_coord();    w.point_y = any_coord();    w.point_z = any_coord();
    w.corner_a_x = any_coord(); w.corner_a_y = any_coord(); w.corner_a_z = any_coord();
    w.corner_b_x = any_coord(); w.corner_b_y = any_coord(); w.corner_b_z = any_coord();
    w.corner_c_x = any_coord(); w.corner_c_y = any_coord(); w.corner_c_z = any_coord();
    return w;
  endfunction

  function automatic logic signed [23:0] small_coord(input int s);
    return 24'($signed($urandom()) >>> s);
  endfunction

  // Point built inside or near the triangle so weights land in range.
  function automatic in_word_t near_triangle_word();
    in_word_t w;
    int s;
    s = $urandom_range(4, 20);
    w = '0;
    w.corner_a_x = small_coord(s); w.corner_a_y = small_coord(s);
    w.corner_a_z = small_coord(s);
    w.corner_b_x = small_coord(s); w.corner_b_y = small_coord(s);
    w.corner_b_z = small_coord(s);
    w.corner_c_x = small_coord(s); w.corner_c_y = small_coord(s);
    w.corner_c_z = small_coord(s);
    w.point_x = 24'((w.corner_a_x + w.corner_b_x + w.corner_c_x) / 3 +
                    ($signed($urandom()) >>> (s + 2)));
    w.point_y = 24'((w.corner_a_y + w.corner_b_y + w.corner_c_y) / 3 +
                    ($signed($urandom()) >>> (s + 2)));
    w.point_z = 24'((w.corner_a_z + w.corner_b_z + w.corner_c_z) / 3 +
                    ($signed($urandom()) >>> (s + 2)));
    return w;
  endfunction

  // Corners on axis-aligned points; each plane in turn gives a dominant axis.
  function automatic in_word_t plane_word(input int axis, input int edge_len);
    in_word_t w;
    logic signed [23:0] e;
    e = 24'(edge_len);
    w = '0;
    case (axis)
      0: begin w.corner_b_y = e; w.corner_c_z = e; w.point_y = 1024; w.point_z = 1024; end
      1: begin w.corner_b_z = e; w.corner_c_x = e; w.point_z = 1024; w.point_x = 1024; end
      default: begin w.corner_b_x = e; w.corner_c_y = e;
                     w.point_x = 1024; w.point_y = 1024; end
    endcase
    return w;
  endfunction

  task automatic test_axes_and_ties;
    in_word_t w;
    for (int a = 0; a < 3; a++) send_word(plane_word(a, 4096));
    // equal normal components everywhere: tie resolves to z
    w = '0;
    w.corner_b_x = 4096; w.corner_b_y = -4096;
    w.corner_c_y = 4096; w.corner_c_z = -4096;
    w.point_x = 100; w.point_y = 200; w.point_z = 300;
    send_word(w);
    // |nx| equal to |ny| above |nz|: y wins
    w = '0;
    w.corner_b_z = 4096; w.corner_c_x = 4096; w.corner_c_y = 4096;
    w.point_x = 500;
    send_word(w);
  endtask

  task automatic test_extremes;
    in_word_t w;
    w = '0;
    send_word(w);                       // all corners equal: degenerate
    w = '1;
    send_word(w);
    w = '0;
    w.corner_a_x = -24'sh800000; w.corner_b_x = 24'sh7FFFFF;
    w.corner_a_y = -24'sh800000; w.corner_c_y = 24'sh7FFFFF;
    w.point_x = 24'sh7FFFFF; w.point_y = -24'sh800000; w.point_z = 24'sh7FFFFF;
    send_word(w);
    // far point with a tiny triangle saturates weights both ways
    w = plane_word(2, 1);
    w.point_x = 24'sh7FFFFF; w.point_y = -24'sh800000;
    send_word(w);
    w.point_x = -24'sh800000; w.point_y = 24'sh7FFFFF;
    send_word(w);
    w = plane_word(2, 4096);
    w.point_x = 24'sh7FFFFF; w.point_y = 24'sh7FFFFF;
    send_word(w);
    // corners themselves: exact unit weights
    w = plane_word(1, 4096); w.point_x = 0; w.point_z = 0; send_word(w);
    w.point_z = 4096; send_word(w);
    w.point_z = 0; w.point_x = 4096; send_word(w);
  endtask

  task automatic test_threshold_edge;
    // normal component here is 4096*4096 = 2^24
    drain();
    write_threshold(32'h0100_0000);
    send_word(plane_word(2, 4096));     // at threshold: degenerate
    send_word(plane_word(2, 4097));     // just above: valid
    drain();
    write_threshold(32'hFFFF_FFFF);
    send_word(plane_word(0, 4096));
    send_word(random_word());
    drain();
    write_threshold('0);
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) stall_mode = $urandom_range(0, 2);
      case ($urandom_range(0, 9))
        0, 1, 2: send_word(random_word());
        3: send_word(plane_word($urandom_range(0, 2), $urandom_range(0, 5000)));
        default: send_word(near_triangle_word());
      endcase
    end
  endtask

  task automatic test_random_thresholds;
    logic [31:0] levels[4];
    levels = '{32'd1, 32'h0000_FFFF, 32'h8000_0000, 32'd0};
    foreach (levels[k]) begin
      drain();
      write_threshold(levels[k]);
      test_random(40);
    end
  endtask

  initial begin
    errors = 0; words_sent = 0; words_checked = 0; degenerate_seen = 0;
    cycles = 0; stall_mode = 0; burst_left = 0; threshold = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_axes_and_ties();
    test_extremes();
    test_threshold_edge();
    stall_mode = 2;
    test_random(240);
    test_random_thresholds();
    drain();
    $display("%0d words sent, %0d checked, %0d degenerate; thresholds 0 to max",
             words_sent, words_checked, degenerate_seen);
    $display("random corners, all three dominant axes, ties and saturation covered");
    if (errors == 0 && weights_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
